// ----- hdl/minv4_pkg.sv -----
// shared types, constants and microprogram tables for the 4x4 matrix inverter
`timescale 1ns / 1ps
`default_nettype none
package minv4_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SINGULAR  = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  localparam logic [3:0] LAST_MINOR_STEP = 4'd8;
  localparam logic [3:0] LAST_ELEM       = 4'd15;
  localparam logic [1:0] LAST_DET_STEP   = 2'd3;

  typedef enum logic [2:0] {
    BSEL_ELEM,
    BSEL_S0,
    BSEL_S1,
    BSEL_S2,
    BSEL_ADJ
  } bsel_t;

  typedef enum logic [2:0] {
    SAVE_NONE,
    SAVE_S0,
    SAVE_S1,
    SAVE_S2,
    SAVE_ADJ,
    SAVE_DET
  } save_t;

  typedef struct packed {
    logic [3:0] a_addr;
    logic [3:0] b_addr;
    bsel_t      b_sel;
    logic       clr;
    logic       sub;
    save_t      save;
  } uop_t;

  typedef struct packed {
    logic       rd_en;
    logic [3:0] rd_addr;
    logic       cap_b;
    logic       mul_start;
    logic       mul_step;
    logic       mul_msb;
    bsel_t      b_sel;
    logic       clr;
    logic       sub;
    save_t      save;
    logic [3:0] k;
    logic       det_chk;
    logic       div_start;
    logic       div_step;
    logic       div_fin;
    logic       run_start;
    logic       emit_ld;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
  } stat_t;

  // column-major element address
  function automatic logic [3:0] pos(input logic [1:0] r, input logic [1:0] c);
    return {c, r};
  endfunction

  // i-th surviving row or column after deleting one
  function automatic logic [1:0] skip_map(input logic [1:0] skip, input logic [1:0] i);
    return (i < skip) ? i : i + 2'd1;
  endfunction

  // 3x3 minor deleting row k[3:2] and column k[1:0]
  function automatic uop_t uop_minor(input logic [3:0] k, input logic [3:0] step);
    logic [1:0] r0, r1, r2, c0, c1, c2;
    uop_t u;
    r0 = skip_map(k[3:2], 2'd0);
    r1 = skip_map(k[3:2], 2'd1);
    r2 = skip_map(k[3:2], 2'd2);
    c0 = skip_map(k[1:0], 2'd0);
    c1 = skip_map(k[1:0], 2'd1);
    c2 = skip_map(k[1:0], 2'd2);
    u.a_addr = pos(r0, c0);
    u.b_addr = pos(r0, c0);
    u.b_sel  = BSEL_ELEM;
    u.clr    = 1'b0;
    u.sub    = 1'b0;
    u.save   = SAVE_NONE;
    case (step)
      4'd0: begin
        u.a_addr = pos(r1, c1); u.b_addr = pos(r2, c2); u.clr = 1'b1;
      end
      4'd1: begin
        u.a_addr = pos(r1, c2); u.b_addr = pos(r2, c1); u.sub = 1'b1; u.save = SAVE_S0;
      end
      4'd2: begin
        u.a_addr = pos(r1, c0); u.b_addr = pos(r2, c2); u.clr = 1'b1;
      end
      4'd3: begin
        u.a_addr = pos(r1, c2); u.b_addr = pos(r2, c0); u.sub = 1'b1; u.save = SAVE_S1;
      end
      4'd4: begin
        u.a_addr = pos(r1, c0); u.b_addr = pos(r2, c1); u.clr = 1'b1;
      end
      4'd5: begin
        u.a_addr = pos(r1, c1); u.b_addr = pos(r2, c0); u.sub = 1'b1; u.save = SAVE_S2;
      end
      4'd6: begin
        u.a_addr = pos(r0, c0); u.b_sel = BSEL_S0; u.clr = 1'b1;
      end
      4'd7: begin
        u.a_addr = pos(r0, c1); u.b_sel = BSEL_S1; u.sub = 1'b1;
      end
      4'd8: begin
        u.a_addr = pos(r0, c2); u.b_sel = BSEL_S2; u.save = SAVE_ADJ;
      end
      default: begin
        u.save = SAVE_NONE;
      end
    endcase
    return u;
  endfunction

  // determinant along the first row: sum of a(0,j) * adj[j]
  function automatic uop_t uop_det(input logic [1:0] j);
    uop_t u;
    u.a_addr = pos(2'd0, j);
    u.b_addr = pos(2'd0, j);
    u.b_sel  = BSEL_ADJ;
    u.clr    = (j == 2'd0);
    u.sub    = 1'b0;
    u.save   = (j == LAST_DET_STEP) ? SAVE_DET : SAVE_NONE;
    return u;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/minv4_if.sv -----
// request channel interfaces for element input and inverse output
`timescale 1ns / 1ps
`default_nettype none
interface minv4_in_if import minv4_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   elem_index;
  logic signed [DATA_WIDTH-1:0] elem_value;
  logic                         start_invert;
  modport source(output valid, elem_index, elem_value, start_invert, input ready);
  modport sink(input valid, elem_index, elem_value, start_invert, output ready);
endinterface

interface minv4_out_if import minv4_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   out_index;
  logic signed [DATA_WIDTH-1:0] out_value;
  logic [1:0]                   status;
  logic                         last_result;
  modport source(output valid, out_index, out_value, status, last_result, input ready);
  modport sink(input valid, out_index, out_value, status, last_result, output ready);
endinterface
`default_nettype wire

// ----- hdl/minv4_ram.sv -----
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module minv4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/minv4_ctrl.sv -----
// sequencer: microprogram for cofactors, determinant, division and result emission
`timescale 1ns / 1ps
`default_nettype none
module minv4_ctrl import minv4_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_fire,
  input  wire logic  in_start,
  output logic       in_ready,
  input  wire logic  out_ready,
  output logic       out_valid,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam int BIT_W     = $clog2(DATA_WIDTH);
  localparam int DIV_STEPS = 3 * DATA_WIDTH + 2 + 2 * FRAC_BITS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_RB, S_RA, S_MS, S_MUL, S_SAVE, S_CHK, S_DIVS, S_DIV, S_RND, S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [3:0]        step_r, step_nxt;
  logic              det_ph_r, det_ph_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [4:0]        e_r, e_nxt;
  logic              out_valid_r, out_valid_nxt;
  uop_t              uop;

  assign uop       = det_ph_r ? uop_det(k_r[1:0]) : uop_minor(k_r, step_r);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    step_nxt      = step_r;
    det_ph_nxt    = det_ph_r;
    bit_nxt       = bit_r;
    dcnt_nxt      = dcnt_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.k         = k_r;
    cmd.b_sel     = uop.b_sel;
    cmd.clr       = uop.clr;
    cmd.sub       = uop.sub;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_start) begin
          state_nxt     = S_RB;
          k_nxt         = '0;
          step_nxt      = '0;
          det_ph_nxt    = 1'b0;
          cmd.run_start = 1'b1;
        end
      end
      S_RB: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = uop.b_addr;
        state_nxt   = S_RA;
      end
      S_RA: begin
        cmd.cap_b   = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = uop.a_addr;
        state_nxt   = S_MS;
      end
      S_MS: begin
        cmd.mul_start = 1'b1;
        bit_nxt       = '0;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.mul_msb  = (bit_r == BIT_W'(DATA_WIDTH - 1));
        if (cmd.mul_msb) begin
          state_nxt = S_SAVE;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      S_SAVE: begin
        cmd.save  = uop.save;
        state_nxt = S_RB;
        if (!det_ph_r) begin
          if (step_r == LAST_MINOR_STEP) begin
            step_nxt = '0;
            if (k_r == LAST_ELEM) begin
              det_ph_nxt = 1'b1;
              k_nxt      = '0;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end else if (k_r[1:0] == LAST_DET_STEP) begin
          state_nxt = S_CHK;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_CHK: begin
        cmd.det_chk = 1'b1;
        k_nxt       = '0;
        e_nxt       = '0;
        state_nxt   = stat.det_zero ? S_EMIT : S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        dcnt_nxt      = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_RND;
        end else begin
          dcnt_nxt = dcnt_r + 1'b1;
        end
      end
      S_RND: begin
        cmd.div_fin = 1'b1;
        if (k_r == LAST_ELEM) begin
          e_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_DIVS;
        end
      end
      S_EMIT: begin
        cmd.k = e_r[3:0];
        if (!out_valid_r || out_ready) begin
          if (!e_r[4]) begin
            cmd.emit_ld   = 1'b1;
            out_valid_nxt = 1'b1;
            e_nxt         = e_r + 1'b1;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      step_r      <= '0;
      det_ph_r    <= 1'b0;
      bit_r       <= '0;
      dcnt_r      <= '0;
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      step_r      <= step_nxt;
      det_ph_r    <= det_ph_nxt;
      bit_r       <= bit_nxt;
      dcnt_r      <= dcnt_nxt;
      e_r         <= e_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/minv4_dp.sv -----
// datapath: element store, serial multiply-accumulate, restoring divider, result registers
`timescale 1ns / 1ps
`default_nettype none
module minv4_dp import minv4_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_fire,
  input  wire logic [3:0]                   in_index,
  input  wire logic [DATA_WIDTH-1:0]        in_value,
  input  wire cmd_t                         cmd,
  output stat_t                             stat,
  output logic [3:0]                        out_index,
  output logic signed [DATA_WIDTH-1:0]      out_value,
  output logic [1:0]                        out_status,
  output logic                              out_last
);

  localparam int W     = DATA_WIDTH;
  localparam int S_W   = 2 * W + 1;  // 2x2 determinant
  localparam int ADJ_W = 3 * W + 2;  // cofactor
  localparam int ACC_W = 4 * W + 4;  // determinant and accumulator
  localparam int Q_W   = W + 1;

  logic [15:0]             valid_r;
  logic [W-1:0]            ram_rdata;
  logic                    rd_vld_r;
  logic [W-1:0]            rd_elem;
  logic [W-1:0]            opb_r;
  logic [W-1:0]            a_sh_r;
  logic [ACC_W-1:0]        b_sh_r;
  logic [ACC_W-1:0]        acc_r;
  logic                    sub_r;
  logic [ACC_W-1:0]        b_sel_val;
  logic                    add_neg;
  logic [S_W-1:0]          s0_r, s1_r, s2_r;
  logic [ADJ_W-1:0]        adj_r [16];
  logic [ACC_W-1:0]        det_r;
  logic [ADJ_W-1:0]        adj_k;
  logic [ADJ_W-1:0]        acc_adj;
  logic [ADJ_W-1:0]        num_r;
  logic [ACC_W-1:0]        d_r;
  logic [ACC_W-1:0]        rem_r;
  logic [Q_W-1:0]          q_r;
  logic                    big_r;
  logic                    neg_r;
  logic [ACC_W:0]          rem_sh;
  logic [ACC_W:0]          rem_diff;
  logic                    q_bit;
  logic                    round_up;
  logic [Q_W:0]            q_rnd;
  logic [Q_W:0]            lim;
  logic                    over;
  logic [Q_W:0]            mag;
  logic [W-1:0]            vals_r [16];
  logic                    sat_r;
  logic                    singular_r;

  minv4_ram #(.WIDTH(W), .DEPTH(16)) u_store (
    .clk   (clk),
    .we    (in_fire),
    .waddr (in_index),
    .wdata (in_value),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (ram_rdata)
  );

  // entries never written read as zero
  assign rd_elem = rd_vld_r ? ram_rdata : '0;
  assign adj_k   = adj_r[cmd.k];
  assign acc_adj = acc_r[ADJ_W-1:0];

  always_comb begin
    case (cmd.b_sel)
      BSEL_ELEM: b_sel_val = {{(ACC_W-W){opb_r[W-1]}}, opb_r};
      BSEL_S0:   b_sel_val = {{(ACC_W-S_W){s0_r[S_W-1]}}, s0_r};
      BSEL_S1:   b_sel_val = {{(ACC_W-S_W){s1_r[S_W-1]}}, s1_r};
      BSEL_S2:   b_sel_val = {{(ACC_W-S_W){s2_r[S_W-1]}}, s2_r};
      BSEL_ADJ:  b_sel_val = {{(ACC_W-ADJ_W){adj_k[ADJ_W-1]}}, adj_k};
      default:   b_sel_val = '0;
    endcase
  end

  // sign bit of the multiplier carries negative weight
  assign add_neg = sub_r ^ cmd.mul_msb;

  assign rem_sh   = {rem_r, num_r[ADJ_W-1]};
  assign rem_diff = rem_sh - {1'b0, d_r};
  assign q_bit    = (rem_sh >= {1'b0, d_r});
  assign round_up = ({rem_r, 1'b0} >= {1'b0, d_r});
  assign q_rnd    = {1'b0, q_r} + (Q_W+1)'(round_up);
  assign lim      = neg_r ? ((Q_W+1)'(1) << (W - 1)) : (((Q_W+1)'(1) << (W - 1)) - 1'b1);
  assign over     = big_r || (q_rnd > lim);
  assign mag      = over ? lim : q_rnd;

  assign stat.det_zero = (det_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      sat_r      <= 1'b0;
      singular_r <= 1'b0;
    end else begin
      if (in_fire) begin
        valid_r[in_index] <= 1'b1;
      end
      if (cmd.run_start) begin
        sat_r      <= 1'b0;
        singular_r <= 1'b0;
      end
      if (cmd.det_chk) begin
        singular_r <= stat.det_zero;
      end
      if (cmd.div_fin && over) begin
        sat_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_vld_r <= valid_r[cmd.rd_addr];
    end
    if (cmd.cap_b) begin
      opb_r <= rd_elem;
    end
    if (cmd.mul_start) begin
      a_sh_r <= rd_elem;
      b_sh_r <= b_sel_val;
      sub_r  <= cmd.sub;
      if (cmd.clr) begin
        acc_r <= '0;
      end
    end
    if (cmd.mul_step) begin
      if (a_sh_r[0]) begin
        acc_r <= acc_r + (b_sh_r ^ {ACC_W{add_neg}}) + ACC_W'(add_neg);
      end
      a_sh_r <= a_sh_r >> 1;
      b_sh_r <= b_sh_r << 1;
    end
    case (cmd.save)
      SAVE_S0:  s0_r <= acc_r[S_W-1:0];
      SAVE_S1:  s1_r <= acc_r[S_W-1:0];
      SAVE_S2:  s2_r <= acc_r[S_W-1:0];
      // checkerboard sign of the cofactor
      SAVE_ADJ: adj_r[cmd.k] <= (cmd.k[0] ^ cmd.k[2]) ? -acc_adj : acc_adj;
      SAVE_DET: det_r <= acc_r;
      default:  ;
    endcase
    if (cmd.det_chk) begin
      d_r <= det_r[ACC_W-1] ? -det_r : det_r;
    end
    if (cmd.div_start) begin
      num_r <= adj_k[ADJ_W-1] ? -adj_k : adj_k;
      rem_r <= '0;
      q_r   <= '0;
      big_r <= 1'b0;
      neg_r <= adj_k[ADJ_W-1] ^ det_r[ACC_W-1];
    end
    if (cmd.div_step) begin
      num_r <= num_r << 1;
      rem_r <= q_bit ? rem_diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
      q_r   <= {q_r[Q_W-2:0], q_bit};
      big_r <= big_r | q_r[Q_W-1];
    end
    if (cmd.div_fin) begin
      vals_r[cmd.k] <= neg_r ? -mag[W-1:0] : mag[W-1:0];
    end
    if (cmd.emit_ld) begin
      out_index  <= cmd.k;
      out_value  <= singular_r ? '0 : vals_r[cmd.k];
      out_status <= singular_r ? ST_SINGULAR : (sat_r ? ST_SATURATED : ST_OK);
      out_last   <= (cmd.k == LAST_ELEM);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/matrix_inverse_4x4_top.sv -----
// top level of the 4x4 fixed-point matrix inverter
// Elements are loaded one per cycle, while the inverter is idle, into a
// 16-entry store at column-major positions; the element with start_invert
// set is stored and starts the inversion. The adjugate and determinant are
// formed exactly by one shared shift-add multiplier (148 products), then
// each inverse element comes from a restoring divider that yields one
// quotient bit per cycle (16 elements; skipped for a singular matrix). The
// sixteen results then leave one per cycle while the sink is ready. The
// default format is Q16.16; no element is accepted from the start element
// until the last result is taken.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_4x4_top import minv4_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  minv4_in_if.sink     in_ch,
  minv4_out_if.source  out_ch
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  minv4_ctrl #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_start  (in_ch.start_invert),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  minv4_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_index   (in_ch.elem_index),
    .in_value   (in_ch.elem_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_index  (out_ch.out_index),
    .out_value  (out_ch.out_value),
    .out_status (out_ch.status),
    .out_last   (out_ch.last_result)
  );

endmodule
`default_nettype wire

// ----- hdl/minv4_checker.sv -----
// port-level checker for the matrix inverter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module minv4_checker import minv4_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [3:0]            out_index,
  input wire logic [DATA_WIDTH-1:0] out_value,
  input wire logic [1:0]            out_status,
  input wire logic                  out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_index))
    else $error("stalled result changed");

  // no new request taken while results are pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while results pending");

  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      !out_valid || out_index == $past(out_index) + 4'd1)
    else $error("result index out of sequence");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SINGULAR |-> out_value == '0)
    else $error("singular run gave nonzero value");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_index == LAST_ELEM)
    else $error("last result flag on wrong index");

endmodule

bind matrix_inverse_4x4_top minv4_checker #(.DATA_WIDTH(DATA_WIDTH)) u_minv4_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_index  (out_ch.out_index),
  .out_value  (out_ch.out_value),
  .out_status (out_ch.status),
  .out_last   (out_ch.last_result)
);
`default_nettype wire
